FILE: sv/lmfe_pkg.sv
`timescale 1ns / 1ps
package lmfe_pkg;

   typedef enum logic [2:0] {
      MODE_WR_WAIT  = 3'd0,
      MODE_WR_SHOWN = 3'd1,
      MODE_FILL     = 3'd2,
      MODE_SET_END  = 3'd3,
      MODE_CLR_TAIL = 3'd4,
      MODE_PHASE    = 3'd5,
      MODE_SCROLL   = 3'd6,
      MODE_TICK     = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      EFF_COPY = 2'd0,
      EFF_DOWN = 2'd1,
      EFF_UP   = 2'd2,
      EFF_ALT  = 2'd3
   } effect_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   // Waiting-buffer access for one cycle
   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [7:0] wr_data;
      logic       clr_en;
      logic [8:0] clr_from;
      logic       rd_en;
      logic [7:0] rd_addr;
   } wbuf_req_type;

   // One transition phase applied to one column
   function automatic logic [7:0] phase_column(
      input logic [7:0]  cur,
      input logic [7:0]  nw,
      input effect_type  eff,
      input logic        odd,
      input logic [2:0]  ph
   );
      logic       down;
      logic [7:0] res;
      begin
         down = 1'b0;
         res  = cur;
         case (eff)
            EFF_DOWN: down = 1'b1;
            EFF_UP:   down = 1'b0;
            default:  down = odd;
         endcase
         if (eff == EFF_COPY) begin
            res = nw;
         end else if (down) begin
            res = {cur[6:0], nw[3'd7 - ph]};
         end else begin
            res = {nw[ph], cur[7:1]};
         end
         return res;
      end
   endfunction

endpackage

FILE: sv/lmfe_cell.sv
`timescale 1ns / 1ps
module lmfe_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  logic [7:0] d_in,
   output logic [7:0] q
);

   logic [7:0] q_ff;
   logic [7:0] q_in;

   assign q_in = shift_en ? d_in : q_ff;
   assign q    = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= 8'd0;
      end else begin
         q_ff <= q_in;
      end
   end

endmodule

FILE: sv/lmfe_wait_buf.sv
`timescale 1ns / 1ps
module lmfe_wait_buf #(
   parameter int DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lmfe_pkg::wbuf_req_type acc,
   output logic [7:0]            rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;
   logic             wr_hit;

   assign wr_hit = acc.wr_en && ({1'b0, acc.wr_addr} < 9'(DEPTH));

   always_comb begin
      valid_in = valid_ff;
      if (acc.clr_en) begin
         for (int p = 0; p < DEPTH; p++) begin
            if (9'(p) >= acc.clr_from) valid_in[p] = 1'b0;
         end
      end
      if (wr_hit) valid_in[acc.wr_addr[AW-1:0]] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (acc.rd_en) rd_valid_ff <= valid_ff[acc.rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) mem[acc.wr_addr[AW-1:0]] <= acc.wr_data;
      if (acc.rd_en) rd_data_ff <= mem[acc.rd_addr[AW-1:0]];
   end

   // entries never written, or cleared, read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : 8'd0;

endmodule

FILE: sv/led_matrix_frame_effects.sv
`timescale 1ns / 1ps
// LED column display frame controller.
// req_* carries one command item (mode plus its operands); rsp_* returns the
// shown frame, one column per item, columns 0..MODULES*8-1 in order, the
// final one flagged by rsp_last, each tagged with the marquee state after
// the command. Commands that change the frame (write shown inside the frame,
// fill, transition phase, tick while scrolling) return a whole frame; the
// others return nothing and finish in the cycle they are accepted.
// The shown frame lives in a ring of MODULES*8 byte cells that rotates one
// column per cycle unless the receiver stalls: the head column (on a scroll
// tick, the next or the waiting column) is updated and enters at the tail
// while it is put out. A frame command moves the state register to emit;
// each column then passes the output register. The waiting buffer is a
// one-port-read memory; transitions read one waiting column per step.
// A stalled receiver freezes the rotation; the output register holds its
// item. req_ready is high whenever no frame is being put out.
// Reset clears the frame, the buffer (per-entry valid bits), end and scroll
// position, and stops the marquee; it is synchronous.
module led_matrix_frame_effects #(
   parameter int MODULES        = 4,
   parameter int BUFFER_COLUMNS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_column_index,
   input  logic [7:0]  req_value,
   input  logic [8:0]  req_text_end,
   input  logic [31:0] req_column_mask,
   input  logic [1:0]  req_effect,
   input  logic [2:0]  req_phase,
   input  logic        req_scroll_on,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_column,
   output logic [7:0]  rsp_pixels,
   output logic        rsp_last,
   output logic        rsp_scroll_active
);

   localparam int FRAME_W = MODULES * 8;
   localparam int KW      = $clog2(FRAME_W);
   localparam logic [KW-1:0] LAST_K  = KW'(FRAME_W - 1);
   localparam logic [9:0]    BUF_END = 10'(BUFFER_COLUMNS);
   localparam logic [9:0]    END_OFF = 10'(FRAME_W - 1);

   lmfe_pkg::state_type  state_ff, state_in;
   lmfe_pkg::mode_type   mode_ff, mode_in, req_mode_e;
   lmfe_pkg::effect_type eff_ff, eff_in;
   lmfe_pkg::wbuf_req_type wacc;

   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      idx_ff, idx_in;
   logic [7:0]         val_ff, val_in;
   logic [FRAME_W-1:0] mask_ff, mask_in;
   logic [2:0]         phase_ff, phase_in;
   logic [8:0]         end_ff, end_in;
   logic [8:0]         pos_ff, pos_in;
   logic               scroll_ff, scroll_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         rsp_column_ff, rsp_column_in;
   logic [7:0]         rsp_pixels_ff, rsp_pixels_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_active_ff, rsp_active_in;

   logic               fire, emits, step;
   logic [8:0]         pos_next;
   logic               stop;
   logic [7:0]         wait_col;
   logic [7:0]         tail_new;
   logic [7:0]         cell_q [FRAME_W];

   assign req_mode_e = lmfe_pkg::mode_type'(req_mode);
   assign req_ready  = (state_ff == lmfe_pkg::ST_IDLE);
   assign fire       = req_valid && req_ready;
   assign step       = (state_ff == lmfe_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign pos_next = pos_ff + 9'd1;
   assign stop     = ({1'b0, pos_next} >= ({1'b0, end_ff} + END_OFF)) ||
                     ({1'b0, pos_next} >= BUF_END);

   always_comb begin
      emits = 1'b0;
      if (fire) begin
         case (req_mode_e)
            lmfe_pkg::MODE_WR_SHOWN: emits = ({1'b0, req_column_index} < 9'(FRAME_W));
            lmfe_pkg::MODE_FILL,
            lmfe_pkg::MODE_PHASE:    emits = 1'b1;
            lmfe_pkg::MODE_TICK:     emits = scroll_ff;
            default:                 emits = 1'b0;
         endcase
      end
   end

   // waiting buffer: commands at accept, transition reads one column a step
   always_comb begin
      wacc          = '0;
      wacc.wr_en    = fire && (req_mode_e == lmfe_pkg::MODE_WR_WAIT);
      wacc.wr_addr  = req_column_index;
      wacc.wr_data  = req_value;
      wacc.clr_en   = fire && (req_mode_e == lmfe_pkg::MODE_CLR_TAIL);
      wacc.clr_from = end_ff;
      if (emits) begin
         wacc.rd_en   = 1'b1;
         wacc.rd_addr = (req_mode_e == lmfe_pkg::MODE_TICK) ? pos_ff[7:0] : 8'd0;
      end else if (step && mode_ff == lmfe_pkg::MODE_PHASE && k_ff != LAST_K) begin
         wacc.rd_en   = 1'b1;
         wacc.rd_addr = 8'(k_ff) + 8'd1;
      end
   end

   lmfe_wait_buf #(.DEPTH(BUFFER_COLUMNS)) u_wbuf (
      .clock   (clock),
      .reset   (reset),
      .acc     (wacc),
      .rd_data (wait_col)
   );

   // value entering at the tail: updated head, or next/waiting column on a tick
   always_comb begin
      case (mode_ff)
         lmfe_pkg::MODE_WR_SHOWN: tail_new = (k_ff == idx_ff) ? val_ff : cell_q[0];
         lmfe_pkg::MODE_FILL:     tail_new = val_ff;
         lmfe_pkg::MODE_PHASE:
            tail_new = mask_ff[FRAME_W-1] ?
               lmfe_pkg::phase_column(cell_q[0], wait_col, eff_ff, k_ff[0], phase_ff) :
               cell_q[0];
         default:                 tail_new = (k_ff == LAST_K) ? wait_col : cell_q[1];
      endcase
   end

   for (genvar i = 0; i < FRAME_W; i++) begin : g_cell
      logic [7:0] d;
      if (i == FRAME_W - 1) begin : g_tail
         assign d = tail_new;
      end else begin : g_mid
         assign d = cell_q[i+1];
      end
      lmfe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (step),
         .d_in     (d),
         .q        (cell_q[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      eff_in    = eff_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      mask_in   = mask_ff;
      phase_in  = phase_ff;
      end_in    = end_ff;
      pos_in    = pos_ff;
      scroll_in = scroll_ff;

      if (fire) begin
         case (req_mode_e)
            lmfe_pkg::MODE_SET_END: end_in = req_text_end;
            lmfe_pkg::MODE_SCROLL: begin
               pos_in    = 9'd0;
               scroll_in = req_scroll_on;
            end
            lmfe_pkg::MODE_TICK: begin
               if (scroll_ff) begin
                  pos_in    = stop ? 9'd0 : pos_next;
                  scroll_in = !stop;
               end
            end
            default: ;
         endcase
      end

      if (emits) begin
         state_in = lmfe_pkg::ST_EMIT;
         mode_in  = req_mode_e;
         eff_in   = lmfe_pkg::effect_type'(req_effect);
         k_in     = '0;
         idx_in   = req_column_index[KW-1:0];
         val_in   = req_value;
         mask_in  = req_column_mask[FRAME_W-1:0];
         phase_in = req_phase;
      end else if (step) begin
         k_in    = k_ff + KW'(1);
         mask_in = mask_ff << 1;
         if (k_ff == LAST_K) state_in = lmfe_pkg::ST_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_column_in = rsp_column_ff;
      rsp_pixels_in = rsp_pixels_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_active_in = rsp_active_ff;
      if (step) begin
         rsp_valid_in  = 1'b1;
         rsp_column_in = 5'(k_ff);
         rsp_pixels_in = tail_new;
         rsp_last_in   = (k_ff == LAST_K);
         rsp_active_in = scroll_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmfe_pkg::ST_IDLE;
         k_ff         <= '0;
         end_ff       <= 9'd0;
         pos_ff       <= 9'd0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         end_ff       <= end_in;
         pos_ff       <= pos_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      eff_ff        <= eff_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      mask_ff       <= mask_in;
      phase_ff      <= phase_in;
      rsp_column_ff <= rsp_column_in;
      rsp_pixels_ff <= rsp_pixels_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column        = rsp_column_ff;
   assign rsp_pixels        = rsp_pixels_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_scroll_active = rsp_active_ff;

endmodule

FILE: sv/lmfe_checker.sv
`timescale 1ns / 1ps
module lmfe_checker #(
   parameter int FRAME_W = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_column,
   input logic [7:0]  rsp_pixels,
   input logic        rsp_last
);

   localparam logic [4:0] LAST_COL = 5'(FRAME_W - 1);

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixels) && $stable(rsp_column))
      else $error("stalled result item changed");

   // last flag marks exactly the final frame column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_column == LAST_COL)))
      else $error("last flag on wrong column");

   // no new command while a frame is partly put out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("command accepted mid-frame");

   // fill always starts a frame
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == lmfe_pkg::MODE_FILL) |=> !req_ready)
      else $error("fill did not start a frame");

   // buffer write completes at once
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == lmfe_pkg::MODE_WR_WAIT) |=> req_ready)
      else $error("buffer write blocked the input");

endmodule

bind led_matrix_frame_effects lmfe_checker #(.FRAME_W(MODULES * 8)) u_lmfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_mode   (req_mode),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_column (rsp_column),
   .rsp_pixels (rsp_pixels),
   .rsp_last   (rsp_last)
);
